// File: src/piq_pkg.sv
package piq_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CODE_W   = 16;
    localparam int SCALE_W  = 33;
    localparam int GAIN_W   = 48;
    localparam int DIVD_W   = 49;
    localparam int DIVS_W   = 33;

    localparam int QUANT_HI   = 32750;
    localparam int QUANT_LO_N = 32751;
    localparam int QUANT_SPAN = 65501;

    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_QUANT = 1'b1;
    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_CAL  = 1'b1;

    typedef struct packed {
        logic                        quant;
        logic signed [SAMPLE_W-1:0]  sample;
        logic signed [SAMPLE_W-1:0]  pmin;
        logic signed [SAMPLE_W-1:0]  pmax;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

endpackage

// File: src/profile_int16_quantizer.sv
// Min/max linear quantizer of a Q15.16 profile to 16-bit codes.
// Input stream s_*: tdata = sample (bits 31:0), tuser = request type
// (0 scan, 1 quantize), tlast marks the final scan word of a profile.
// Output stream m_*: tuser = kind (0 code, 1 calibration); tdata from
// bit 0 up: code[15:0], offset[47:16], scale[80:48], flat[81], zero pad.
// Scan words without tlast produce no output and are taken one per cycle
// while the four-entry queue between range tracker and engine has room.
// Quantize words pass the engine one at a time, in order (pop, difference,
// two partial-product multipliers, sum, saturate); m_tvalid rises once
// the saturated code is loaded into the free result register.
// The last scan word divides offset and scale by the constant span by
// folding, then runs the serial gain divider; its calibration word
// follows once the divider is done and the result register is free.
// Quantize words after it use the new calibration.
// Reset clears range, offset and gain, so codes are zero until the first
// calibration. When m_tready is low the result register holds; the engine
// stalls behind it and the queue fills, then s_tready drops.
module profile_int16_quantizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample[31:0]
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // code, offset, scale, flat, pad
    output logic        m_tuser    // kind
);

    logic                            q_full;
    logic                            q_push;
    logic                            q_pop;
    logic                            q_not_empty;
    piq_pkg::entry_t                 q_in;
    piq_pkg::entry_t                 q_head;
    piq_pkg::div_req_t               div_req;
    logic                            div_done;
    logic [piq_pkg::DIVD_W-1:0]      div_quo;

    piq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .req_type (s_tuser),
        .sample   (s_tdata),
        .last     (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    piq_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    piq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    piq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .div_req     (div_req),
        .div_done    (div_done),
        .div_quo     (div_quo),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_data    (m_tdata)
    );

endmodule

// File: src/piq_fifo.sv
module piq_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  piq_pkg::entry_t  push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output piq_pkg::entry_t  head
);

    localparam int DEPTH = 4;

    piq_pkg::entry_t mem [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign full      = (count_reg == 3'(DEPTH));
    assign not_empty = (count_reg != 3'd0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

endmodule

// File: src/piq_front.sv
module piq_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic signed [piq_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  last,
    input  logic                                  q_full,
    output logic                                  q_push,
    output piq_pkg::entry_t                       q_data
);

    logic signed [piq_pkg::SAMPLE_W-1:0] min_reg;
    logic signed [piq_pkg::SAMPLE_W-1:0] max_reg;
    logic                                started_reg;
    logic signed [piq_pkg::SAMPLE_W-1:0] min_next;
    logic signed [piq_pkg::SAMPLE_W-1:0] max_next;
    logic                                take;
    logic                                is_scan;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign is_scan  = (req_type == piq_pkg::REQ_SCAN);

    always_comb
    begin
        if (!started_reg)
        begin
            min_next = sample;
            max_next = sample;
        end
        else
        begin
            min_next = (sample < min_reg) ? sample : min_reg;
            max_next = (sample > max_reg) ? sample : max_reg;
        end
    end

    // scan words without last only update the running range
    assign q_push        = take && (!is_scan || last);
    assign q_data.quant  = !is_scan;
    assign q_data.sample = sample;
    assign q_data.pmin   = min_next;
    assign q_data.pmax   = max_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= '0;
            max_reg     <= '0;
            started_reg <= 1'b0;
        end
        else if (take && is_scan)
        begin
            min_reg     <= min_next;
            max_reg     <= max_next;
            started_reg <= !last;
        end
    end

endmodule

// File: src/piq_div.sv
module piq_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  piq_pkg::div_req_t                 req,
    output logic                              done,
    output logic [piq_pkg::DIVD_W-1:0]        quotient
);

    logic                              busy_reg;
    logic [5:0]                        cnt_reg;
    logic [piq_pkg::DIVS_W-1:0]        den_reg;
    logic [piq_pkg::DIVS_W-1:0]        rem_reg;
    logic [piq_pkg::DIVD_W-1:0]        quo_reg;
    logic                              done_reg;
    logic [piq_pkg::DIVS_W:0]          trial;
    logic                              fits;

    assign trial    = {rem_reg, quo_reg[piq_pkg::DIVD_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
            end
            else if (busy_reg)
            begin
                // one quotient bit per cycle, restoring
                if (fits)
                begin
                    rem_reg <= piq_pkg::DIVS_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= trial[piq_pkg::DIVS_W-1:0];
                end
                quo_reg <= {quo_reg[piq_pkg::DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(piq_pkg::DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/piq_back.sv
module piq_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_not_empty,
    input  piq_pkg::entry_t         q_head,
    output logic                    q_pop,
    output piq_pkg::div_req_t       div_req,
    input  logic                    div_done,
    input  logic [piq_pkg::DIVD_W-1:0] div_quo,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_kind,
    output logic [87:0]             out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_QDIFF, S_QMUL, S_QSUM, S_QOUT,
        S_CMUL, S_COFF, S_COFFW, S_CSW, S_CGAIN, S_CGW, S_COUT
    } state_t;

    state_t state_reg;
    piq_pkg::entry_t ent_reg;

    logic signed [piq_pkg::SAMPLE_W-1:0] offset_reg;
    logic [piq_pkg::GAIN_W-1:0]          gain_reg;

    logic [32:0]  a_reg;
    logic         neg_reg;
    logic [64:0]  plo_reg;
    logic [48:0]  phi_reg;
    logic [48:0]  qv_reg;

    logic signed [48:0] p1_reg;
    logic signed [48:0] p2_reg;
    logic [31:0]        diff_reg;
    logic signed [31:0] off_new_reg;
    logic [32:0]        s_reg;
    logic               flat_reg;
    logic [48:0]        kn_reg;
    logic [48:0]        kq_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [87:0]        out_data_reg;

    logic signed [32:0] d;
    logic signed [48:0] num;
    logic [48:0]        num_mag;
    logic [80:0]        prod_sum;
    logic [15:0]        code;
    logic               slot_free;
    logic               out_load;
    logic [32:0]        k_hi;
    logic [15:0]        k_lo;
    logic [48:0]        k_fold;
    logic               k_done;
    logic [48:0]        k_quo;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = slot_free && ((state_reg == S_QOUT) || (state_reg == S_COUT));
    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;

    assign d = {ent_reg.sample[31], ent_reg.sample} - {offset_reg[31], offset_reg};
    assign num = p1_reg + p2_reg;
    assign num_mag = num[48] ? 49'(-num) : 49'(num);
    assign prod_sum = {16'd0, plo_reg} + {phi_reg, 32'd0} + 81'(33'h0_8000_0000);

    // division by the span: hi*2^16 + lo = hi*span + (35*hi + lo)
    assign k_hi   = kn_reg[48:16];
    assign k_lo   = kn_reg[15:0];
    assign k_fold = {11'd0, k_hi, 5'd0} + {15'd0, k_hi, 1'b0} + {16'd0, k_hi}
                  + {33'd0, k_lo};
    assign k_done = (k_hi == 33'd0);
    assign k_quo  = kq_reg + ((kn_reg >= 49'(piq_pkg::QUANT_SPAN)) ? 49'd1 : 49'd0);

    always_comb
    begin
        if (qv_reg > 49'd32768)
        begin
            code = neg_reg ? 16'h8000 : 16'h7fff;
        end
        else if (neg_reg)
        begin
            code = 16'(-qv_reg[16:0]);
        end
        else
        begin
            code = (qv_reg[15:0] == 16'h8000) ? 16'h7fff : qv_reg[15:0];
        end
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_CGAIN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b1, 48'd0} + 49'(s_reg[32:1]);
                div_req.divisor  = s_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offset_reg    <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= piq_pkg::KIND_CODE;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        ent_reg   <= q_head;
                        state_reg <= q_head.quant ? S_QDIFF : S_CMUL;
                    end
                end
                S_QDIFF:
                begin
                    neg_reg   <= d[32];
                    a_reg     <= d[32] ? 33'(-d) : 33'(d);
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    plo_reg   <= 65'(a_reg) * 65'(gain_reg[31:0]);
                    phi_reg   <= 49'(a_reg) * 49'(gain_reg[47:32]);
                    state_reg <= S_QSUM;
                end
                S_QSUM:
                begin
                    qv_reg    <= prod_sum[80:32];
                    state_reg <= S_QOUT;
                end
                S_QOUT:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg  <= piq_pkg::KIND_CODE;
                        out_data_reg  <= {72'd0, code};
                        state_reg     <= S_IDLE;
                    end
                end
                S_CMUL:
                begin
                    p1_reg    <= 49'(ent_reg.pmin) * 49'sd32750;
                    p2_reg    <= 49'(ent_reg.pmax) * 49'sd32751;
                    diff_reg  <= 32'(ent_reg.pmax - ent_reg.pmin);
                    state_reg <= S_COFF;
                end
                S_COFF:
                begin
                    neg_reg   <= num[48];
                    kn_reg    <= num_mag + 49'(piq_pkg::QUANT_HI);
                    kq_reg    <= '0;
                    state_reg <= S_COFFW;
                end
                S_COFFW:
                begin
                    if (k_done)
                    begin
                        off_new_reg <= neg_reg ? 32'(-k_quo[31:0]) : k_quo[31:0];
                        kn_reg      <= 49'({diff_reg, 16'd0} + 48'(piq_pkg::QUANT_HI));
                        kq_reg      <= '0;
                        state_reg   <= S_CSW;
                    end
                    else
                    begin
                        kn_reg <= k_fold;
                        kq_reg <= kq_reg + 49'(k_hi);
                    end
                end
                S_CSW:
                begin
                    if (k_done)
                    begin
                        if (diff_reg == 32'd0)
                        begin
                            s_reg    <= {1'b1, 32'd0};
                            flat_reg <= 1'b1;
                        end
                        else
                        begin
                            s_reg    <= (k_quo == 49'd0) ? 33'd1 : k_quo[32:0];
                            flat_reg <= 1'b0;
                        end
                        state_reg <= S_CGAIN;
                    end
                    else
                    begin
                        kn_reg <= k_fold;
                        kq_reg <= kq_reg + 49'(k_hi);
                    end
                end
                S_CGAIN:
                begin
                    state_reg <= S_CGW;
                end
                S_CGW:
                begin
                    if (div_done)
                    begin
                        gain_reg   <= div_quo[48] ? {48{1'b1}} : div_quo[47:0];
                        offset_reg <= off_new_reg;
                        state_reg  <= S_COUT;
                    end
                end
                S_COUT:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg  <= piq_pkg::KIND_CAL;
                        out_data_reg  <= {6'd0, flat_reg, s_reg, off_new_reg, 16'd0};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
